// ===== sv/eight_bit_alu_register_status_unit_macros.svh =====
// assertion macros used by the checker file of the alu register status unit
`ifndef EIGHT_BIT_ALU_REGISTER_STATUS_UNIT_MACROS_SVH
`define EIGHT_BIT_ALU_REGISTER_STATUS_UNIT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ALURSU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("alursu check failed");

// next-cycle implication, checked outside reset
`define ALURSU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("alursu check failed");

`endif

// ===== sv/alursu_pkg.sv =====
// types, constants and helpers of the alu register status unit
package alursu_pkg;

	// beat layout, input side
	localparam int IN_W       = 24;
	localparam int CMD_LSB    = 0;
	localparam int CMD_W      = 5;
	localparam int SEL_LSB    = 5;
	localparam int SEL_W      = 2;
	localparam int OPD_LSB    = 7;
	localparam int MODE_LSB   = 15;
	localparam int MODE_W     = 2;
	localparam int STEP_LSB   = 17;
	localparam int STEP_W     = 2;

	// beat layout, output side
	localparam int OUT_W      = 32;
	localparam int RES_LSB    = 0;
	localparam int PSL_LSB    = 8;
	localparam int PSU_LSB    = 16;
	localparam int TAKEN_BIT  = 24;
	localparam int PAD_W      = 7;

	localparam int NREGS      = 7;
	localparam int RIX_W      = 3;
	localparam int BANK_OFS   = 3;

	// lower status bit positions
	localparam int PSL_CC_HI  = 7;
	localparam int PSL_CC_LO  = 6;
	localparam int PSL_IDC    = 5;
	localparam int PSL_RS     = 4;
	localparam int PSL_WC     = 3;
	localparam int PSL_OVF    = 2;
	localparam int PSL_COM    = 1;
	localparam int PSL_C      = 0;

	// upper status: writable bits and bits that never change
	localparam logic [7:0] PSU_WR_MASK = 8'h67;
	localparam logic [7:0] PSU_RESET   = 8'h20;
	localparam int PSU_S      = 7;

	localparam logic [7:0] SIGN_FLIP   = 8'h80;
	localparam logic [3:0] BCD_MAX     = 4'd9;
	localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
	localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
	localparam int ROT_IDC_BIT = 5;

	typedef logic [1:0] cc_t;
	localparam cc_t CC_ZERO = 2'b00;
	localparam cc_t CC_POS  = 2'b01;
	localparam cc_t CC_NEG  = 2'b10;

	localparam logic [1:0] COND_EQ  = 2'd0;
	localparam logic [1:0] COND_GT  = 2'd1;
	localparam logic [1:0] COND_LT  = 2'd2;
	localparam logic [1:0] COND_ALL = 2'd3;

	localparam logic [1:0] SRC_REG   = 2'd0;
	localparam logic [1:0] SRC_IMM   = 2'd1;
	localparam logic [1:0] SRC_IDX   = 2'd2;
	localparam logic [1:0] SRC_SPARE = 2'd3;

	localparam logic [1:0] STEP_INC = 2'd1;
	localparam logic [1:0] STEP_DEC = 2'd2;

	typedef enum logic [4:0] {
		CMD_LOD  = 5'd0,
		CMD_EOR  = 5'd1,
		CMD_AND  = 5'd2,
		CMD_IOR  = 5'd3,
		CMD_ADD  = 5'd4,
		CMD_SUB  = 5'd5,
		CMD_COM  = 5'd6,
		CMD_STR  = 5'd7,
		CMD_DAR  = 5'd8,
		CMD_RRR  = 5'd9,
		CMD_RRL  = 5'd10,
		CMD_TMI  = 5'd11,
		CMD_TPSU = 5'd12,
		CMD_TPSL = 5'd13,
		CMD_LPSU = 5'd14,
		CMD_LPSL = 5'd15,
		CMD_SPSU = 5'd16,
		CMD_SPSL = 5'd17,
		CMD_CPSU = 5'd18,
		CMD_CPSL = 5'd19,
		CMD_PPSU = 5'd20,
		CMD_PPSL = 5'd21,
		CMD_RED  = 5'd22,
		CMD_WRT  = 5'd23,
		CMD_BCT  = 5'd24,
		CMD_BCF  = 5'd25,
		CMD_BRN  = 5'd26,
		CMD_BIX  = 5'd27,
		CMD_IDX  = 5'd28
	} cmd_t;

	// condition code of a plain value result
	function automatic cc_t cc_of(input logic [7:0] v);
		if (v == 8'h00) begin
			return CC_ZERO;
		end
		return v[7] ? CC_NEG : CC_POS;
	endfunction

endpackage

// ===== sv/eight_bit_alu_register_status_unit.sv =====
// Register file, ALU and status unit of an 8-bit processor.
// Usage:
//   s_t* channel carries one operation per beat: command, register select,
//   operand fetched outside, source mode and index step.
//   m_t* channel returns one beat per operation: the value involved, the
//   lower and upper status bytes after the operation, and the branch-test bit.
// Path: a beat accepted at a clock edge sits in the input register,
//   moves into the result register once that register is empty or being
//   taken, and is offered on m_tdata from then on.
// Throughput: one operation per cycle while m_tready does not stall the
//   output; the register file and status bytes are read and updated as
//   each operation executes, so a dependent operation may follow directly.
// Reset: arst_n low clears R0..R3 in both banks and the lower status byte,
//   sets the upper status byte to interrupt inhibit only, and empties both
//   the input and the result register.
// Stall: while m_tready is low the result register holds its beat; the
//   input register still takes one more beat, then s_tready drops until the
//   result is taken.
module eight_bit_alu_register_status_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// command[4:0], reg_sel[6:5], operand[14:7], source_mode[16:15],
	// index_step[18:17], zero fill[23:19]
	input  logic [alursu_pkg::IN_W-1:0]  s_tdata,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// result[7:0], status_low[15:8], status_high[23:16], taken[24],
	// zero fill[31:25]
	output logic [alursu_pkg::OUT_W-1:0] m_tdata
);
	import alursu_pkg::*;

	logic              valid_s1;
	cmd_t              cmd_s1;
	logic [1:0]        sel_s1;
	logic [7:0]        opd_s1;
	logic [1:0]        mode_s1;
	logic [1:0]        step_s1;

	logic [7:0]        rf_q [NREGS];
	logic [7:0]        psl_q;
	logic [7:0]        psu_q;
	logic              out_valid_q;
	logic [OUT_W-1:0]  out_data_q;

	logic              adv;
	logic [RIX_W-1:0]  rn;
	logic [RIX_W-1:0]  dst;
	logic [7:0]        r0;
	logic [7:0]        rrn;
	logic [7:0]        a;
	logic [7:0]        b;
	logic [8:0]        add_s;
	logic [4:0]        add_lo;
	logic [8:0]        sub_d;
	logic [4:0]        sub_lo;
	logic              cin;
	logic              bin;
	logic [7:0]        daa1;
	logic [7:0]        daa2;
	logic [7:0]        adj;
	logic              cond_hit;

	logic [7:0]        psl_d;
	logic [7:0]        psu_d;
	logic [7:0]        res;
	logic              tkn;
	logic              wen;
	logic [RIX_W-1:0]  waddr;
	logic [7:0]        wdata;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// register number with bank select applied; r0 has no bank
	always_comb begin
		if (sel_s1 == 2'd0) begin
			rn = '0;
		end else if (psl_q[PSL_RS]) begin
			rn = RIX_W'({1'b0, sel_s1}) + RIX_W'(BANK_OFS);
		end else begin
			rn = RIX_W'(sel_s1);
		end
	end

	assign r0  = rf_q[0];
	assign rrn = rf_q[rn];
	assign a   = (mode_s1 == SRC_IMM) ? rrn : r0;
	assign b   = (mode_s1 == SRC_REG) ? rrn : opd_s1;
	assign dst = (mode_s1 == SRC_IMM) ? rn : '0;

	assign cin    = psl_q[PSL_WC] & psl_q[PSL_C];
	assign bin    = psl_q[PSL_WC] & ~psl_q[PSL_C];
	assign add_s  = {1'b0, a} + {1'b0, b} + {8'h00, cin};
	assign add_lo = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'h0, cin};
	assign sub_d  = {1'b0, a} - {1'b0, b} - {8'h00, bin};
	assign sub_lo = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'h0, bin};

	assign daa1 = ((rrn[3:0] > BCD_MAX) || psl_q[PSL_IDC]) ? rrn + DAA_LO_ADJ : rrn;
	assign daa2 = ((daa1[7:4] > BCD_MAX) || psl_q[PSL_C]) ? daa1 + DAA_HI_ADJ : daa1;

	always_comb begin
		if (step_s1 == STEP_INC) begin
			adj = rrn + 8'd1;
		end else if (step_s1 == STEP_DEC) begin
			adj = rrn - 8'd1;
		end else begin
			adj = rrn;
		end
	end

	always_comb begin
		unique case (sel_s1)
			COND_EQ: cond_hit = (psl_q[PSL_CC_HI:PSL_CC_LO] == CC_ZERO);
			COND_GT: cond_hit = (psl_q[PSL_CC_HI:PSL_CC_LO] == CC_POS);
			COND_LT: cond_hit = (psl_q[PSL_CC_HI:PSL_CC_LO] == CC_NEG);
			default: cond_hit = 1'b1;
		endcase
	end

	always_comb begin
		logic       rot_out;
		logic       rot_in;
		logic [7:0] rot_r;
		logic [7:0] ca;
		logic [7:0] cb;

		rot_out = (cmd_s1 == CMD_RRL) ? rrn[7] : rrn[0];
		rot_in  = psl_q[PSL_WC] ? psl_q[PSL_C] : rot_out;
		rot_r   = (cmd_s1 == CMD_RRL) ? {rrn[6:0], rot_in} : {rot_in, rrn[7:1]};
		ca      = psl_q[PSL_COM] ? a : a ^ SIGN_FLIP;
		cb      = psl_q[PSL_COM] ? b : b ^ SIGN_FLIP;

		psl_d = psl_q;
		psu_d = psu_q;
		res   = '0;
		tkn   = 1'b0;
		wen   = 1'b0;
		waddr = dst;
		wdata = '0;

		unique case (cmd_s1)
			CMD_LOD, CMD_EOR, CMD_AND, CMD_IOR: begin
				unique case (cmd_s1)
					CMD_LOD: res = b;
					CMD_EOR: res = a ^ b;
					CMD_AND: res = a & b;
					default: res = a | b;
				endcase
				psl_d[PSL_CC_HI:PSL_CC_LO] = cc_of(res);
				wen   = 1'b1;
				wdata = res;
			end
			CMD_ADD: begin
				res = add_s[7:0];
				psl_d[PSL_C]   = add_s[8];
				psl_d[PSL_IDC] = add_lo[4];
				psl_d[PSL_OVF] = ~(a[7] ^ b[7]) & (a[7] ^ res[7]);
				if (!add_s[8]) begin
					psl_d[PSL_CC_HI:PSL_CC_LO] = CC_POS;
				end else begin
					psl_d[PSL_CC_HI:PSL_CC_LO] = (res == 8'h00) ? CC_ZERO : CC_NEG;
				end
				wen   = 1'b1;
				wdata = res;
			end
			CMD_SUB: begin
				res = sub_d[7:0];
				psl_d[PSL_C]   = ~sub_d[8];
				psl_d[PSL_IDC] = ~sub_lo[4];
				psl_d[PSL_OVF] = (a[7] ^ b[7]) & (a[7] ^ res[7]);
				if (!sub_d[8]) begin
					psl_d[PSL_CC_HI:PSL_CC_LO] = (res == 8'h00) ? CC_ZERO : CC_POS;
				end else begin
					psl_d[PSL_CC_HI:PSL_CC_LO] = CC_NEG;
				end
				wen   = 1'b1;
				wdata = res;
			end
			CMD_COM: begin
				if (ca > cb) begin
					psl_d[PSL_CC_HI:PSL_CC_LO] = CC_POS;
				end else if (ca == cb) begin
					psl_d[PSL_CC_HI:PSL_CC_LO] = CC_ZERO;
				end else begin
					psl_d[PSL_CC_HI:PSL_CC_LO] = CC_NEG;
				end
			end
			CMD_STR: begin
				// register mode copies r0 into rn; the others only report
				res = (mode_s1 == SRC_IMM) ? rrn : r0;
				if (mode_s1 == SRC_REG) begin
					wen   = 1'b1;
					waddr = rn;
					wdata = r0;
				end
			end
			CMD_DAR: begin
				res   = daa2;
				psl_d[PSL_CC_HI:PSL_CC_LO] = cc_of(daa2);
				wen   = 1'b1;
				waddr = rn;
				wdata = daa2;
			end
			CMD_RRR, CMD_RRL: begin
				res = rot_r;
				if (psl_q[PSL_WC]) begin
					psl_d[PSL_C]   = rot_out;
					psl_d[PSL_OVF] = rrn[7] ^ rot_r[7];
					psl_d[PSL_IDC] = rot_r[ROT_IDC_BIT];
				end
				psl_d[PSL_CC_HI:PSL_CC_LO] = cc_of(rot_r);
				wen   = 1'b1;
				waddr = rn;
				wdata = rot_r;
			end
			CMD_TMI: begin
				psl_d[PSL_CC_HI:PSL_CC_LO] = ((rrn & opd_s1) == opd_s1) ? CC_ZERO : CC_NEG;
			end
			CMD_TPSU: begin
				psl_d[PSL_CC_HI:PSL_CC_LO] = ((psu_q & opd_s1) == opd_s1) ? CC_ZERO : CC_NEG;
			end
			CMD_TPSL: begin
				psl_d[PSL_CC_HI:PSL_CC_LO] = ((psl_q & opd_s1) == opd_s1) ? CC_ZERO : CC_NEG;
			end
			CMD_LPSU: psu_d = (psu_q & ~PSU_WR_MASK) | (r0 & PSU_WR_MASK);
			CMD_LPSL: psl_d = r0;
			CMD_SPSU, CMD_SPSL: begin
				res = (cmd_s1 == CMD_SPSU) ? psu_q : psl_q;
				psl_d[PSL_CC_HI:PSL_CC_LO] = cc_of(res);
				wen   = 1'b1;
				waddr = '0;
				wdata = res;
			end
			CMD_CPSU: psu_d = psu_q & ~(opd_s1 & PSU_WR_MASK);
			CMD_CPSL: psl_d = psl_q & ~opd_s1;
			CMD_PPSU: psu_d = psu_q | (opd_s1 & PSU_WR_MASK);
			CMD_PPSL: psl_d = psl_q | opd_s1;
			CMD_RED: begin
				res   = opd_s1;
				psl_d[PSL_CC_HI:PSL_CC_LO] = cc_of(opd_s1);
				wen   = 1'b1;
				waddr = rn;
				wdata = opd_s1;
			end
			CMD_WRT: begin
				res = rrn;
				psl_d[PSL_CC_HI:PSL_CC_LO] = cc_of(rrn);
			end
			CMD_BCT: tkn = cond_hit;
			CMD_BCF: tkn = (sel_s1 != COND_ALL) && !cond_hit;
			CMD_BRN: tkn = (rrn != 8'h00);
			CMD_BIX: begin
				tkn   = (adj != 8'h00);
				wen   = 1'b1;
				waddr = rn;
				wdata = adj;
			end
			CMD_IDX: begin
				res   = adj;
				wen   = 1'b1;
				waddr = rn;
				wdata = adj;
			end
			default: begin
				// unused command codes leave all state alone
			end
		endcase
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			cmd_s1  <= cmd_t'(s_tdata[CMD_LSB +: CMD_W]);
			sel_s1  <= s_tdata[SEL_LSB +: SEL_W];
			opd_s1  <= s_tdata[OPD_LSB +: 8];
			// mode three acts as indexed, step three as no step
			mode_s1 <= (s_tdata[MODE_LSB +: MODE_W] == SRC_SPARE) ?
				SRC_IDX : s_tdata[MODE_LSB +: MODE_W];
			step_s1 <= s_tdata[STEP_LSB +: STEP_W];
		end
	end

	// architectural state, updated when the beat moves into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NREGS; i++) begin
				rf_q[i] <= '0;
			end
			psl_q       <= '0;
			psu_q       <= PSU_RESET;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				psl_q <= psl_d;
				psu_q <= psu_d;
				if (wen) begin
					rf_q[waddr] <= wdata;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			out_data_q <= {{PAD_W{1'b0}}, tkn, psu_d, psl_d, res};
		end
	end

endmodule

// ===== sv/alursu_chk.sv =====
// port-level checker for the alu register status unit, bound to the top level
`include "eight_bit_alu_register_status_unit_macros.svh"

module alursu_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         m_tvalid,
	input logic                         m_tready,
	input logic [alursu_pkg::OUT_W-1:0] m_tdata
);
	import alursu_pkg::*;

	// a stalled result beat stays put
	`ALURSU_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// sign and unused upper status bits are never written
	`ALURSU_ASSERT_NOW(a_psu_fixed, m_tvalid, m_tdata[PSU_LSB + PSU_S] == 1'b0 && m_tdata[PSU_LSB + 4 -: 2] == 2'b00)

	// branch tests report no value
	`ALURSU_ASSERT_NOW(a_taken_no_res, m_tvalid && m_tdata[TAKEN_BIT], m_tdata[RES_LSB +: 8] == 8'h00)

	// fill bits above taken stay zero
	`ALURSU_ASSERT_NOW(a_pad_zero, m_tvalid, m_tdata[OUT_W-1 -: PAD_W] == '0)

endmodule

bind eight_bit_alu_register_status_unit alursu_chk u_alursu_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/tb_eight_bit_alu_register_status_unit.sv =====
// testbench for the alu register status unit: directed table, random bursts, shadow predictor
module tb_eight_bit_alu_register_status_unit;
	import alursu_pkg::*;

	localparam int RESET_CYCLES = 10;
	localparam int RAND_ITEMS   = 1075;
	localparam int HOLD_CYCLES  = 96;
	localparam int STALL_LIMIT  = 1000;
	localparam int DRAIN_CYCLES = 8;
	localparam int DIR_ROWS     = 38;

	localparam logic [1:0] MODE_IDX   = SRC_IDX;
	localparam logic [1:0] MODE_SPARE = SRC_SPARE;
	localparam logic [1:0] STEP_NONE  = 2'd0;
	localparam logic [1:0] STEP_SPARE = 2'd3;
	localparam logic [4:0] CMD_SPARE_LO = 5'd29;
	localparam logic [4:0] CMD_SPARE_HI = 5'd31;

	typedef enum logic [1:0] {
		SINK_OPEN,
		SINK_LIGHT,
		SINK_ALTERNATE,
		SINK_HEAVY
	} sink_mode_t;

	typedef struct packed {
		logic [4:0] fill;
		logic [1:0] step;
		logic [1:0] mode;
		logic [7:0] opd;
		logic [1:0] sel;
		logic [4:0] cmd;
	} op_beat_t;

	typedef struct packed {
		logic [6:0] fill;
		logic       taken;
		logic [7:0] psu;
		logic [7:0] psl;
		logic [7:0] res;
	} outcome_t;

	typedef struct packed {
		logic [4:0] cmd;
		logic [1:0] sel;
		logic [7:0] opd;
		logic [1:0] mode;
		logic [1:0] step;
		logic       typed;
		logic [7:0] w_res;
		logic [7:0] w_psl;
		logic [7:0] w_psu;
		logic       w_taken;
	} dir_row_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata = '0;
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;

	// shadow copy of the register file and both status bytes
	logic [7:0] regs_sh [NREGS];
	logic [7:0] psw_lo;
	logic [7:0] psw_hi;

	outcome_t alu_outcomes [$];
	int       errors = 0;
	int       results_seen = 0;
	int       beats_sent = 0;
	int       hold_reqs = 0;
	int       holds_done = 0;
	bit       cmd_hit [32];

	logic [7:0] corner_bytes [6] = '{8'h00, 8'hFF, 8'h7F, 8'h80, 8'h99, 8'h0F};

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{CMD_STR,  2'd1,     8'h00, SRC_IMM,    STEP_NONE,  1'b1, 8'h00, 8'h00, 8'h20, 1'b0},
		'{CMD_LOD,  2'd0,     8'hFF, MODE_IDX,   STEP_NONE,  1'b1, 8'hFF, 8'h80, 8'h20, 1'b0},
		'{CMD_ADD,  2'd0,     8'h01, MODE_IDX,   STEP_NONE,  1'b1, 8'h00, 8'h21, 8'h20, 1'b0},
		'{CMD_SUB,  2'd0,     8'h01, MODE_IDX,   STEP_NONE,  1'b1, 8'hFF, 8'h80, 8'h20, 1'b0},
		'{CMD_PPSL, 2'd0,     8'h0A, MODE_IDX,   STEP_NONE,  1'b1, 8'h00, 8'h8A, 8'h20, 1'b0},
		'{CMD_COM,  2'd0,     8'h7F, MODE_IDX,   STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_CPSL, 2'd0,     8'h02, MODE_IDX,   STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_COM,  2'd0,     8'h7F, MODE_IDX,   STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_ADD,  2'd2,     8'h80, SRC_IMM,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_EOR,  2'd1,     8'h00, SRC_REG,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_AND,  2'd2,     8'hA5, SRC_IMM,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_IOR,  2'd0,     8'h5A, MODE_SPARE, STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_RRR,  2'd0,     8'h00, SRC_IMM,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_RRL,  2'd0,     8'h00, SRC_IMM,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_CPSL, 2'd0,     8'hFF, MODE_IDX,   STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_RRL,  2'd2,     8'h00, SRC_IMM,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_DAR,  2'd0,     8'h00, SRC_IMM,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_PPSL, 2'd0,     8'h10, MODE_IDX,   STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_RED,  2'd3,     8'hC3, SRC_IMM,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_STR,  2'd2,     8'h00, SRC_REG,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_TMI,  2'd3,     8'hC0, SRC_IMM,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_RED,  2'd0,     8'hC0, SRC_IMM,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_LPSL, 2'd0,     8'h00, SRC_REG,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_BCT,  COND_ALL, 8'h00, SRC_REG,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_BCF,  COND_EQ,  8'h00, SRC_REG,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_BCF,  COND_ALL, 8'h00, SRC_REG,    STEP_NONE,  1'b1, 8'h00, 8'hC0, 8'h20, 1'b0},
		'{CMD_LPSU, 2'd0,     8'h00, SRC_REG,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_CPSU, 2'd0,     8'hFF, MODE_IDX,   STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_PPSU, 2'd0,     8'hFF, MODE_IDX,   STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_SPSU, 2'd0,     8'h00, SRC_REG,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_SPSL, 2'd0,     8'h00, SRC_REG,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_TPSU, 2'd0,     8'h40, MODE_IDX,   STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_TPSL, 2'd0,     8'h01, MODE_IDX,   STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_BIX,  2'd1,     8'h00, SRC_REG,    STEP_DEC,   1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_IDX,  2'd1,     8'h00, SRC_REG,    STEP_SPARE, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_BRN,  2'd1,     8'h00, SRC_REG,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_WRT,  2'd2,     8'h00, SRC_REG,    STEP_NONE,  1'b0, 8'h00, 8'h00, 8'h00, 1'b0},
		'{CMD_SPARE_HI, 2'd1, 8'h55, SRC_IMM,    STEP_INC,   1'b0, 8'h00, 8'h00, 8'h00, 1'b0}
	};

	eight_bit_alu_register_status_unit u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic void put_cc(input cc_t cc);
		psw_lo[PSL_CC_HI:PSL_CC_LO] = cc;
	endfunction

	function automatic void set_value_cc(input logic [7:0] v);
		if (v == 8'h00) begin
			put_cc(CC_ZERO);
		end else begin
			put_cc(v[7] ? CC_NEG : CC_POS);
		end
	endfunction

	function automatic logic cond_holds(input logic [1:0] cond);
		case (cond)
			COND_EQ: return psw_lo[PSL_CC_HI:PSL_CC_LO] == CC_ZERO;
			COND_GT: return psw_lo[PSL_CC_HI:PSL_CC_LO] == CC_POS;
			COND_LT: return psw_lo[PSL_CC_HI:PSL_CC_LO] == CC_NEG;
			default: return 1'b1;
		endcase
	endfunction

	// with carry linked the carry rotates through, otherwise the outgoing bit wraps
	function automatic logic [7:0] rotate_val(input logic [7:0] v, input logic left);
		logic       obit;
		logic       ibit;
		logic [7:0] r;
		obit = left ? v[7] : v[0];
		ibit = psw_lo[PSL_WC] ? psw_lo[PSL_C] : obit;
		r = left ? {v[6:0], ibit} : {ibit, v[7:1]};
		if (psw_lo[PSL_WC]) begin
			psw_lo[PSL_C]   = obit;
			psw_lo[PSL_OVF] = v[7] ^ r[7];
			psw_lo[PSL_IDC] = r[ROT_IDC_BIT];
		end
		set_value_cc(r);
		return r;
	endfunction

	function automatic logic [7:0] step_index(input logic [2:0] rn, input logic [1:0] step);
		if (step == STEP_INC) begin
			regs_sh[rn] = regs_sh[rn] + 8'd1;
		end else if (step == STEP_DEC) begin
			regs_sh[rn] = regs_sh[rn] - 8'd1;
		end
		return regs_sh[rn];
	endfunction

	// executes one operation on the shadow state and returns the beat it should produce
	function automatic outcome_t run_alu_op(input op_beat_t op);
		logic [1:0] mode;
		logic [2:0] rn;
		logic [2:0] dst;
		logic [7:0] a;
		logic [7:0] b;
		logic [7:0] v;
		logic [8:0] wide;
		logic [4:0] nib;
		logic       cin;
		outcome_t   o;
		o = '0;
		mode = (op.mode == MODE_SPARE) ? MODE_IDX : op.mode;
		rn = (op.sel == 2'd0) ? 3'd0 :
			(psw_lo[PSL_RS] ? 3'(op.sel) + 3'(BANK_OFS) : 3'(op.sel));
		a = (mode == SRC_IMM) ? regs_sh[rn] : regs_sh[0];
		b = (mode == SRC_REG) ? regs_sh[rn] : op.opd;
		dst = (mode == SRC_IMM) ? rn : 3'd0;
		case (op.cmd)
			CMD_LOD, CMD_EOR, CMD_AND, CMD_IOR: begin
				case (op.cmd)
					CMD_LOD: v = b;
					CMD_EOR: v = a ^ b;
					CMD_AND: v = a & b;
					default: v = a | b;
				endcase
				set_value_cc(v);
				regs_sh[dst] = v;
				o.res = v;
			end
			CMD_ADD: begin
				cin = psw_lo[PSL_WC] & psw_lo[PSL_C];
				wide = {1'b0, a} + {1'b0, b} + 9'(cin);
				nib = {1'b0, a[3:0]} + {1'b0, b[3:0]} + 5'(cin);
				v = wide[7:0];
				psw_lo[PSL_C]   = wide[8];
				psw_lo[PSL_IDC] = nib[4];
				psw_lo[PSL_OVF] = ~(a[7] ^ b[7]) & (a[7] ^ v[7]);
				put_cc(!wide[8] ? CC_POS : ((v == 8'h00) ? CC_ZERO : CC_NEG));
				regs_sh[dst] = v;
				o.res = v;
			end
			CMD_SUB: begin
				// borrow in is the inverted carry
				cin = psw_lo[PSL_WC] & ~psw_lo[PSL_C];
				wide = {1'b0, a} - {1'b0, b} - 9'(cin);
				nib = {1'b0, a[3:0]} - {1'b0, b[3:0]} - 5'(cin);
				v = wide[7:0];
				psw_lo[PSL_C]   = ~wide[8];
				psw_lo[PSL_IDC] = ~nib[4];
				psw_lo[PSL_OVF] = (a[7] ^ b[7]) & (a[7] ^ v[7]);
				put_cc(wide[8] ? CC_NEG : ((v == 8'h00) ? CC_ZERO : CC_POS));
				regs_sh[dst] = v;
				o.res = v;
			end
			CMD_COM: begin
				if (!psw_lo[PSL_COM]) begin
					a[7] = ~a[7];
					b[7] = ~b[7];
				end
				put_cc((a > b) ? CC_POS : ((a == b) ? CC_ZERO : CC_NEG));
			end
			CMD_STR: begin
				if (mode == SRC_REG) begin
					regs_sh[rn] = regs_sh[0];
				end
				o.res = (mode == SRC_IMM) ? regs_sh[rn] : regs_sh[0];
			end
			CMD_DAR: begin
				v = regs_sh[rn];
				if (v[3:0] > BCD_MAX || psw_lo[PSL_IDC]) begin
					v = v + 8'h06;
				end
				if (v[7:4] > BCD_MAX || psw_lo[PSL_C]) begin
					v = v + 8'h60;
				end
				regs_sh[rn] = v;
				set_value_cc(v);
				o.res = v;
			end
			CMD_RRR, CMD_RRL: begin
				v = rotate_val(regs_sh[rn], op.cmd == CMD_RRL);
				regs_sh[rn] = v;
				o.res = v;
			end
			CMD_TMI: put_cc(((regs_sh[rn] & op.opd) == op.opd) ? CC_ZERO : CC_NEG);
			CMD_TPSU: put_cc(((psw_hi & op.opd) == op.opd) ? CC_ZERO : CC_NEG);
			CMD_TPSL: put_cc(((psw_lo & op.opd) == op.opd) ? CC_ZERO : CC_NEG);
			CMD_LPSU: psw_hi = (psw_hi & ~PSU_WR_MASK) | (regs_sh[0] & PSU_WR_MASK);
			CMD_LPSL: psw_lo = regs_sh[0];
			CMD_SPSU, CMD_SPSL: begin
				v = (op.cmd == CMD_SPSU) ? psw_hi : psw_lo;
				regs_sh[0] = v;
				set_value_cc(v);
				o.res = v;
			end
			CMD_CPSU: psw_hi = psw_hi & ~(op.opd & PSU_WR_MASK);
			CMD_CPSL: psw_lo = psw_lo & ~op.opd;
			CMD_PPSU: psw_hi = psw_hi | (op.opd & PSU_WR_MASK);
			CMD_PPSL: psw_lo = psw_lo | op.opd;
			CMD_RED: begin
				regs_sh[rn] = op.opd;
				set_value_cc(op.opd);
				o.res = op.opd;
			end
			CMD_WRT: begin
				set_value_cc(regs_sh[rn]);
				o.res = regs_sh[rn];
			end
			CMD_BCT: o.taken = cond_holds(op.sel);
			CMD_BCF: o.taken = (op.sel != COND_ALL) && !cond_holds(op.sel);
			CMD_BRN: o.taken = regs_sh[rn] != 8'h00;
			CMD_BIX: o.taken = step_index(rn, op.step) != 8'h00;
			CMD_IDX: o.res = step_index(rn, op.step);
			default: ;
		endcase
		o.psl = psw_lo;
		o.psu = psw_hi;
		return o;
	endfunction

	// drives one beat from a falling edge and returns at the falling edge after it is taken
	task automatic offer(input op_beat_t op, input logic typed, input outcome_t typed_val);
		outcome_t o;
		s_tvalid <= 1'b1;
		s_tdata  <= op;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		o = run_alu_op(op);
		alu_outcomes.push_back(typed ? typed_val : o);
		cmd_hit[op.cmd] = 1'b1;
		beats_sent++;
		@(negedge clk);
	endtask

	task automatic idle_gap(input int n);
		s_tvalid <= 1'b0;
		s_tdata  <= IN_W'($urandom);
		repeat (n) @(negedge clk);
	endtask

	task automatic check_field(input string fname, input logic [7:0] want, input logic [7:0] got);
		if (got !== want) begin
			errors++;
			$display("[%0t] %s mismatch: expected %h, got %h", $time, fname, want, got);
		end
	endtask

	always @(posedge clk) begin : result_check
		outcome_t got;
		outcome_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = m_tdata;
			if (alu_outcomes.size() == 0) begin
				errors++;
				$display("[%0t] result beat with nothing pending: expected none, got %h",
					$time, m_tdata);
			end else begin
				want = alu_outcomes.pop_front();
				results_seen++;
				check_field("result", want.res, got.res);
				check_field("status_low", want.psl, got.psl);
				check_field("status_high", want.psu, got.psu);
				check_field("taken", 8'(want.taken), 8'(got.taken));
			end
		end
	end

	// output side stalls in segments of differing density, plus requested long hold-offs
	initial begin : sink
		int         seg_left;
		sink_mode_t sink_mode;
		logic       phase;
		seg_left = 0;
		sink_mode = SINK_OPEN;
		phase = 1'b0;
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_reqs != holds_done) begin
				holds_done++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end else begin
				if (seg_left == 0) begin
					sink_mode = sink_mode_t'($urandom_range(3, 0));
					seg_left = $urandom_range(64, 8);
				end
				seg_left--;
				phase = ~phase;
				case (sink_mode)
					SINK_OPEN:      m_tready <= 1'b1;
					SINK_LIGHT:     m_tready <= ($urandom_range(3, 0) != 0);
					SINK_ALTERNATE: m_tready <= phase;
					default:        m_tready <= ($urandom_range(2, 0) == 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		int idle;
		idle = 0;
		wait (arst_n);
		while (idle < STALL_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
				idle = 0;
			end else begin
				idle++;
			end
		end
		$display("[%0t] no beat moved for %0d cycles, %0d results outstanding",
			$time, idle, alu_outcomes.size());
		$display("eight_bit_alu_register_status_unit regression: fail");
		$finish;
	end

	initial begin : stimulus
		op_beat_t op;
		outcome_t typed_val;
		int       n_real;
		int       burst;
		int       next_hold;
		int       next_pause;
		int       n_cmds;
		for (int i = 0; i < NREGS; i++) begin
			regs_sh[i] = 8'h00;
		end
		psw_lo = 8'h00;
		psw_hi = PSU_RESET;
		n_real = 0;
		next_hold = 0;
		next_pause = 350;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			op = '0;
			op.cmd  = dir_rows[i].cmd;
			op.sel  = dir_rows[i].sel;
			op.opd  = dir_rows[i].opd;
			op.mode = dir_rows[i].mode;
			op.step = dir_rows[i].step;
			typed_val = '0;
			typed_val.res   = dir_rows[i].w_res;
			typed_val.psl   = dir_rows[i].w_psl;
			typed_val.psu   = dir_rows[i].w_psu;
			typed_val.taken = dir_rows[i].w_taken;
			offer(op, dir_rows[i].typed, typed_val);
			if ($urandom_range(3, 0) == 0) begin
				idle_gap($urandom_range(3, 1));
			end
		end

		while (n_real < RAND_ITEMS) begin
			burst = $urandom_range(24, 1);
			// long back-to-back burst against a held-off output so the input backs up
			if (n_real >= next_hold) begin
				hold_reqs++;
				next_hold = (next_hold == 0) ? 600 : RAND_ITEMS + 1;
				burst = 32;
			end
			for (int k = 0; k < burst; k++) begin
				op = '0;
				if ($urandom_range(99, 0) < 3) begin
					op.cmd = 5'($urandom_range(CMD_SPARE_HI, CMD_SPARE_LO));
				end else begin
					op.cmd = 5'($urandom_range(CMD_IDX, CMD_LOD));
				end
				op.sel = 2'($urandom_range(3, 0));
				if ($urandom_range(3, 0) == 0) begin
					op.opd = corner_bytes[$urandom_range(5, 0)];
				end else begin
					op.opd = 8'($urandom);
				end
				op.mode = ($urandom_range(19, 0) == 0) ? MODE_SPARE : 2'($urandom_range(2, 0));
				op.step = ($urandom_range(19, 0) == 0) ? STEP_SPARE : 2'($urandom_range(2, 0));
				offer(op, 1'b0, '0);
				if (op.cmd <= CMD_IDX) begin
					n_real++;
				end
			end
			if (n_real >= next_pause) begin
				next_pause = (next_pause == 350) ? 900 : RAND_ITEMS + 1;
				s_tvalid <= 1'b0;
				do @(negedge clk); while (alu_outcomes.size() != 0);
			end else if ($urandom_range(3, 0) != 0) begin
				idle_gap($urandom_range(8, 1));
			end
		end

		s_tvalid <= 1'b0;
		while (alu_outcomes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		n_cmds = 0;
		for (int c = 0; c < 32; c++) begin
			n_cmds += cmd_hit[c];
		end
		$display("sent %0d operations (%0d from the directed table) over %0d command codes",
			beats_sent, DIR_ROWS, n_cmds);
		$display("checked %0d result beats, %0d mismatches, %0d output hold-offs",
			results_seen, errors, holds_done);
		if (errors == 0) begin
			$display("eight_bit_alu_register_status_unit regression: pass");
		end else begin
			$display("eight_bit_alu_register_status_unit regression: fail");
		end
		$finish;
	end

endmodule

// ===== eight_bit_alu_register_status_unit.f =====
+incdir+sv
sv/alursu_pkg.sv
sv/eight_bit_alu_register_status_unit.sv
sv/alursu_chk.sv
tb/tb_eight_bit_alu_register_status_unit.sv
